// ===== src/rnlp_pkg.sv =====
// Shared types, character codes and digit decode for the radix literal parser.
package rnlp_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int OUT_VALUE_BITS     = 32;

   typedef enum logic [1:0] {
      OP_CONTINUE = 2'd0,
      OP_BEGIN    = 2'd1,
      OP_PREFIX   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_BIN  = 3'd1,
      MODE_OCT  = 3'd2,
      MODE_DEC  = 3'd3,
      MODE_HEX  = 3'd4
   } mode_type;

   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CHAR_1  = 8'h31;
   localparam logic [7:0] CHAR_7  = 8'h37;
   localparam logic [7:0] CHAR_9  = 8'h39;
   localparam logic [7:0] CHAR_LA = 8'h61;
   localparam logic [7:0] CHAR_LF = 8'h66;
   localparam logic [7:0] CHAR_UA = 8'h41;
   localparam logic [7:0] CHAR_UF = 8'h46;
   localparam logic [7:0] CHAR_LB = 8'h62;
   localparam logic [7:0] CHAR_UB = 8'h42;
   localparam logic [7:0] CHAR_LO = 8'h6f;
   localparam logic [7:0] CHAR_UO = 8'h4f;
   localparam logic [7:0] CHAR_LX = 8'h78;
   localparam logic [7:0] CHAR_UX = 8'h58;
   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

   typedef struct packed {
      logic       hit;
      logic [3:0] digit;
   } digit_type;

   typedef struct packed {
      logic [OUT_VALUE_BITS-1:0] value;
      mode_type                  radix;
      logic                      consumed;
   } rsp_type;

   function automatic digit_type digit_of(mode_type mode, logic [7:0] c);
      digit_type d;
      d.hit   = 1'b0;
      d.digit = c[3:0];
      case (mode)
         MODE_BIN: d.hit = (c == CHAR_0) || (c == CHAR_1);
         MODE_OCT: d.hit = c inside {[CHAR_0:CHAR_7]};
         MODE_DEC: d.hit = c inside {[CHAR_0:CHAR_9]};
         MODE_HEX: begin
            if (c inside {[CHAR_0:CHAR_9]}) begin
               d.hit = 1'b1;
            end else if (c inside {[CHAR_LA:CHAR_LF]}) begin
               d.hit   = 1'b1;
               d.digit = 4'(c - CHAR_LA + HEX_LETTER_BASE);
            end else if (c inside {[CHAR_UA:CHAR_UF]}) begin
               d.hit   = 1'b1;
               d.digit = 4'(c - CHAR_UA + HEX_LETTER_BASE);
            end
         end
         default: d.hit = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ===== src/radix_number_literal_parser.sv =====
// Top level: character-at-a-time integer literal parser with output skid buffer.
// One character word is taken per cycle with no bubbles while req_stall is low; the digit update (shift, or
// times-ten add) and the mode decode are combinational between the request port and
// the mode/accumulator registers. A finished number lands in an output register
// backed by one skid entry, so the request side only stalls while both hold a word;
// a word that finds the output register still full goes to the skid entry. Values wrap
// modulo 2^VALUE_BITS and are presented on 32 bits (zero extended or truncated).
module radix_number_literal_parser #(
   parameter int VALUE_BITS = rnlp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_op,
   input  logic [7:0]                           req_char_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rnlp_pkg::OUT_VALUE_BITS-1:0]  rsp_value,
   output logic [2:0]                           rsp_radix_used,
   output logic                                 rsp_char_consumed
);
   import rnlp_pkg::*;

   mode_type              mode_ff, mode_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_type               skid_ff, skid_in;

   logic                  req_accept;
   logic                  rsp_take;
   logic                  res_hit;
   rsp_type               res;
   digit_type             dec_digit;
   digit_type             cur_digit;
   logic [VALUE_BITS-1:0] digit_ext;
   logic [VALUE_BITS+OUT_VALUE_BITS-1:0] acc_wide;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   assign dec_digit = digit_of(MODE_DEC, req_char_in);
   assign cur_digit = digit_of(mode_ff, req_char_in);
   assign digit_ext = VALUE_BITS'(cur_digit.digit);
   assign acc_wide  = {{OUT_VALUE_BITS{1'b0}}, acc_ff};

   // next state of the parse
   always_comb begin
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      res_hit      = 1'b0;
      res.value    = '0;
      res.radix    = MODE_IDLE;
      res.consumed = 1'b0;
      if (req_accept) begin
         case (op_type'(req_op))
            OP_BEGIN: begin
               if (dec_digit.hit) begin
                  mode_in = MODE_DEC;
                  acc_in  = VALUE_BITS'(dec_digit.digit);
               end else begin
                  mode_in   = MODE_IDLE;
                  acc_in    = '0;
                  res_hit   = 1'b1;
                  res.radix = MODE_DEC;
               end
            end
            OP_PREFIX: begin
               acc_in = '0;
               if ((req_char_in == CHAR_LB) || (req_char_in == CHAR_UB)) begin
                  mode_in = MODE_BIN;
               end else if ((req_char_in == CHAR_LO) || (req_char_in == CHAR_UO)) begin
                  mode_in = MODE_OCT;
               end else if ((req_char_in == CHAR_LX) || (req_char_in == CHAR_UX)) begin
                  mode_in = MODE_HEX;
               end else begin
                  // unknown prefix letter: zero, letter eaten
                  mode_in      = MODE_IDLE;
                  res_hit      = 1'b1;
                  res.consumed = 1'b1;
               end
            end
            OP_CONTINUE: begin
               if (mode_ff != MODE_IDLE) begin
                  if (cur_digit.hit) begin
                     case (mode_ff)
                        MODE_BIN: acc_in = (acc_ff << 1) | digit_ext;
                        MODE_OCT: acc_in = (acc_ff << 3) | digit_ext;
                        MODE_DEC: acc_in = (acc_ff << 3) + (acc_ff << 1) + digit_ext;
                        default:  acc_in = (acc_ff << 4) | digit_ext;
                     endcase
                  end else begin
                     mode_in   = MODE_IDLE;
                     acc_in    = '0;
                     res_hit   = 1'b1;
                     res.value = acc_wide[OUT_VALUE_BITS-1:0];
                     res.radix = mode_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // output register and skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (res_hit) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         acc_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         acc_ff        <= acc_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_value         = out_ff.value;
   assign rsp_radix_used    = out_ff.radix;
   assign rsp_char_consumed = out_ff.consumed;

   // skid entry is only ever filled behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // bad-prefix word is the only one that eats its character
   a_consumed_radix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_consumed == (rsp_radix_used == MODE_IDLE)))
      else $error("char_consumed does not match radix");

   // an unused op code leaves the parse untouched
   a_unused_op: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op_type'(req_op) == OP_RESERVED))
       |=> ($stable(mode_ff) && $stable(acc_ff)))
      else $error("unused op changed parse state");

   // a continue while idle produces no word
   a_idle_continue: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op_type'(req_op) == OP_CONTINUE) && (mode_ff == MODE_IDLE)
       && !out_valid_ff) |=> !out_valid_ff)
      else $error("word from continue while idle");

   // a word that ends a literal restarts the parse idle with a clear accumulator
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (res_hit && (op_type'(req_op) == OP_CONTINUE))
       |=> ((mode_ff == MODE_IDLE) && (acc_ff == '0)))
      else $error("parse state not cleared after literal end");

endmodule
